// ===== hdl/sfpc_pkg.sv =====
`default_nettype none
package sfpc_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned POSITION_BITS    = 16;
    localparam int unsigned ACC_BITS         = 21;
    localparam int unsigned RATE_BITS        = 8;
    localparam int unsigned DURATION_BITS    = 16;
    localparam int unsigned OP_BITS          = 3;
    localparam int unsigned STATUS_BITS      = 2;
    localparam int unsigned CFG_INDEX_BITS   = 2;
    localparam int unsigned CFG_DATA_BITS    = 16;

    // Timed move sizing: (speed * duration + 500) / 1000, with the division done as
    // a shift by three followed by a reciprocal multiplication for the factor 125.
    localparam int unsigned PROD_BITS      = RATE_BITS + DURATION_BITS;
    localparam int unsigned ROUND_BIAS     = 500;
    localparam int unsigned DIV_PRE_SHIFT  = 3;
    localparam int unsigned SCALED_BITS    = PROD_BITS - DIV_PRE_SHIFT;
    localparam int unsigned DIV_SHIFT      = 28;
    localparam int unsigned RECIP_BITS     = 22;
    localparam int unsigned DIV_RECIP      = 2147484;
    localparam int unsigned RECIP_PROD_BITS = SCALED_BITS + RECIP_BITS;
    localparam int unsigned QUOT_BITS      = 15;

    localparam int unsigned MIN_POSITION_RESET = 0;
    localparam int unsigned MAX_POSITION_RESET = 7000;
    localparam int unsigned STEP_RATE_RESET    = 250;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [ACC_BITS-1:0]      acc_t;
    typedef logic [RATE_BITS-1:0]     rate_t;
    typedef logic [QUOT_BITS-1:0]     quot_t;

    localparam acc_t ACC_RELOAD = acc_t'(TICKS_PER_SECOND);

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK     = 3'd0,
        OP_ABSOLUTE = 3'd1,
        OP_RELATIVE = 3'd2,
        OP_TIMED    = 3'd3,
        OP_SYNC     = 3'd4,
        OP_ABORT    = 3'd5
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_AT_TARGET = 2'd0,
        STATUS_MOVING    = 2'd1,
        STATUS_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_POSITION = 2'd0,
        CFG_MAX_POSITION = 2'd1,
        CFG_STEP_RATE    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [OP_BITS-1:0]       operation;
        pos_t                     amount;
        logic                     outward;
        rate_t                    move_speed;
        logic [DURATION_BITS-1:0] duration_ms;
    } cmd_t;

    typedef struct packed {
        logic                   step_pulse;
        logic                   step_outward;
        pos_t                   position_now;
        pos_t                   position_goal;
        logic [STATUS_BITS-1:0] status;
    } result_t;

    typedef struct packed {
        pos_t current_pos;
        pos_t target_pos;
        acc_t rate_accumulator;
    } motion_t;

    typedef struct packed {
        pos_t  min_position;
        pos_t  max_position;
        rate_t step_rate;
    } settings_t;

endpackage
`default_nettype wire

// ===== hdl/sfpc_cmd_if.sv =====
`default_nettype none
interface sfpc_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [sfpc_pkg::OP_BITS-1:0]          operation;
    sfpc_pkg::pos_t                        amount;
    logic                                  outward;
    sfpc_pkg::rate_t                       move_speed;
    logic [sfpc_pkg::DURATION_BITS-1:0]    duration_ms;

    modport source (output valid, operation, amount, outward, move_speed, duration_ms,
                    input ready);
    modport sink (input valid, operation, amount, outward, move_speed, duration_ms,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/sfpc_result_if.sv =====
`default_nettype none
interface sfpc_result_if;
    logic                               valid;
    logic                               ready;
    logic                               step_pulse;
    logic                               step_outward;
    sfpc_pkg::pos_t                     position_now;
    sfpc_pkg::pos_t                     position_goal;
    logic [sfpc_pkg::STATUS_BITS-1:0]   status;

    modport source (output valid, step_pulse, step_outward, position_now, position_goal,
                    status, input ready);
    modport sink (input valid, step_pulse, step_outward, position_now, position_goal,
                  status, output ready);
endinterface
`default_nettype wire

// ===== hdl/sfpc_cfg_if.sv =====
`default_nettype none
interface sfpc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [sfpc_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [sfpc_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sfpc_move_unit.sv =====
`default_nettype none
module sfpc_move_unit (
    input  sfpc_pkg::settings_t settings,
    input  sfpc_pkg::motion_t   motion,
    input  sfpc_pkg::cmd_t      cmd,
    input  sfpc_pkg::quot_t     timed_steps,
    output sfpc_pkg::motion_t   motion_next,
    output sfpc_pkg::result_t   result_next
);

    sfpc_pkg::pos_t                     cur;
    sfpc_pkg::pos_t                     tgt;
    sfpc_pkg::rate_t                    rate;
    sfpc_pkg::acc_t                     acc_sum;
    sfpc_pkg::pos_t                     steps;
    logic [sfpc_pkg::POSITION_BITS:0]   out_sum;
    sfpc_pkg::pos_t                     in_diff;
    sfpc_pkg::pos_t                     rel_target;
    sfpc_pkg::pos_t                     clipped;
    sfpc_pkg::pos_t                     abs_target;
    logic                               sync_bad;
    logic                               pulse;
    logic                               dir;
    logic                               rejected;
    sfpc_pkg::motion_t                  nxt;

    assign cur     = motion.current_pos;
    assign tgt     = motion.target_pos;
    assign rate    = (settings.step_rate == '0) ? sfpc_pkg::rate_t'(1) : settings.step_rate;
    assign acc_sum = motion.rate_accumulator + sfpc_pkg::acc_t'(rate);

    assign steps   = (sfpc_pkg::op_t'(cmd.operation) == sfpc_pkg::OP_TIMED)
                   ? sfpc_pkg::pos_t'(timed_steps) : cmd.amount;
    assign out_sum = {1'b0, cur} + {1'b0, steps};
    assign in_diff = cur - steps;

    always_comb
    begin
        if (cmd.outward)
        begin
            if (out_sum <= {1'b0, settings.max_position})
            begin
                rel_target = out_sum[sfpc_pkg::POSITION_BITS-1:0];
            end
            else
            begin
                rel_target = settings.max_position;
            end
        end
        else
        begin
            if ((cur >= steps) && (in_diff >= settings.min_position))
            begin
                rel_target = in_diff;
            end
            else
            begin
                rel_target = settings.min_position;
            end
        end
    end

    assign clipped    = (cmd.amount < settings.max_position) ? cmd.amount
                                                             : settings.max_position;
    assign abs_target = (clipped > settings.min_position) ? clipped : settings.min_position;
    assign sync_bad   = (cmd.amount < settings.min_position)
                     || (cmd.amount > settings.max_position);

    always_comb
    begin
        nxt      = motion;
        pulse    = 1'b0;
        dir      = 1'b0;
        rejected = 1'b0;
        case (sfpc_pkg::op_t'(cmd.operation))
            sfpc_pkg::OP_TICK:
            begin
                if (cur != tgt)
                begin
                    dir = (tgt > cur);
                    nxt.rate_accumulator = acc_sum;
                    if (acc_sum >= sfpc_pkg::ACC_RELOAD)
                    begin
                        nxt.rate_accumulator = acc_sum - sfpc_pkg::ACC_RELOAD;
                        pulse = 1'b1;
                        nxt.current_pos = dir ? (cur + 1'b1) : (cur - 1'b1);
                    end
                end
            end
            sfpc_pkg::OP_ABSOLUTE:
            begin
                nxt.target_pos = abs_target;
                nxt.rate_accumulator = sfpc_pkg::ACC_RELOAD;
            end
            sfpc_pkg::OP_RELATIVE, sfpc_pkg::OP_TIMED:
            begin
                nxt.target_pos = rel_target;
                nxt.rate_accumulator = sfpc_pkg::ACC_RELOAD;
            end
            sfpc_pkg::OP_SYNC:
            begin
                if (sync_bad)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    nxt.current_pos = cmd.amount;
                    nxt.target_pos = cmd.amount;
                    nxt.rate_accumulator = sfpc_pkg::ACC_RELOAD;
                end
            end
            sfpc_pkg::OP_ABORT:
            begin
                nxt.target_pos = cur;
                nxt.rate_accumulator = sfpc_pkg::ACC_RELOAD;
            end
            default:
            begin
                rejected = 1'b1;
            end
        endcase

        if (nxt.current_pos == nxt.target_pos)
        begin
            nxt.rate_accumulator = sfpc_pkg::ACC_RELOAD;
        end
        else
        begin
            dir = (nxt.target_pos > nxt.current_pos);
        end
    end

    always_comb
    begin
        motion_next               = nxt;
        result_next.step_pulse    = pulse;
        result_next.step_outward  = dir;
        result_next.position_now  = nxt.current_pos;
        result_next.position_goal = nxt.target_pos;
        if (rejected)
        begin
            result_next.status = sfpc_pkg::STATUS_REJECTED;
        end
        else if (nxt.current_pos != nxt.target_pos)
        begin
            result_next.status = sfpc_pkg::STATUS_MOVING;
        end
        else
        begin
            result_next.status = sfpc_pkg::STATUS_AT_TARGET;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/stepper_focuser_position_controller_top.sv =====
// A command transaction is registered in the s1 stage, then the s2 stage, then the result
// register, which drives its result transaction. One command per cycle unless result.ready
// stalls the pipeline; the speed-times-duration product, the reciprocal division by 1000 and
// the position update each occupy one pipeline register stage.
// Reset (rst_n, asynchronous, active low) sets positions to zero, the accumulator to one
// million and the registers to 0, 7000 and 250, and empties the pipeline.
`default_nettype none
module stepper_focuser_position_controller_top (
    input  logic           clk,
    input  logic           rst_n,
    sfpc_cmd_if.sink       cmd,
    sfpc_result_if.source  result,
    sfpc_cfg_if.sink       cfg
);

    logic                                     s1_valid_reg;
    sfpc_pkg::cmd_t                           s1_cmd_reg;
    logic [sfpc_pkg::PROD_BITS-1:0]           s1_prod_reg;
    logic [sfpc_pkg::PROD_BITS-1:0]           s1_prod_next;
    logic                                     s2_valid_reg;
    sfpc_pkg::cmd_t                           s2_cmd_reg;
    sfpc_pkg::quot_t                          s2_quot_reg;
    sfpc_pkg::quot_t                          s2_quot_next;
    logic                                     out_valid_reg;
    sfpc_pkg::result_t                        out_result_reg;
    sfpc_pkg::result_t                        out_result_next;
    sfpc_pkg::motion_t                        motion_reg;
    sfpc_pkg::motion_t                        motion_next;
    sfpc_pkg::settings_t                      settings_reg;
    sfpc_pkg::cmd_t                           cmd_word;
    logic [sfpc_pkg::PROD_BITS-1:0]           rounded;
    logic [sfpc_pkg::SCALED_BITS-1:0]         scaled;
    logic [sfpc_pkg::RECIP_PROD_BITS-1:0]     recip_prod;
    logic                                     out_ready;
    logic                                     s2_ready;
    logic                                     s1_ready;

    assign out_ready = !out_valid_reg || result.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cmd.ready = s1_ready;
    assign cfg.ready = 1'b1;

    assign cmd_word.operation   = cmd.operation;
    assign cmd_word.amount      = cmd.amount;
    assign cmd_word.outward     = cmd.outward;
    assign cmd_word.move_speed  = cmd.move_speed;
    assign cmd_word.duration_ms = cmd.duration_ms;

    assign s1_prod_next = sfpc_pkg::PROD_BITS'(cmd.move_speed)
                        * sfpc_pkg::PROD_BITS'(cmd.duration_ms);

    assign rounded      = s1_prod_reg + sfpc_pkg::PROD_BITS'(sfpc_pkg::ROUND_BIAS);
    assign scaled       = rounded[sfpc_pkg::PROD_BITS-1:sfpc_pkg::DIV_PRE_SHIFT];
    assign recip_prod   = sfpc_pkg::RECIP_PROD_BITS'(scaled)
                        * sfpc_pkg::RECIP_PROD_BITS'(sfpc_pkg::DIV_RECIP);
    assign s2_quot_next = recip_prod[sfpc_pkg::DIV_SHIFT +: sfpc_pkg::QUOT_BITS];

    sfpc_move_unit u_move (
        .settings    (settings_reg),
        .motion      (motion_reg),
        .cmd         (s2_cmd_reg),
        .timed_steps (s2_quot_reg),
        .motion_next (motion_next),
        .result_next (out_result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_cmd_reg  <= cmd_word;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_ready)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_quot_reg <= s2_quot_next;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_result_reg <= out_result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg.current_pos      <= '0;
            motion_reg.target_pos       <= '0;
            motion_reg.rate_accumulator <= sfpc_pkg::ACC_RELOAD;
        end
        else if (out_ready && s2_valid_reg)
        begin
            motion_reg <= motion_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.min_position <= sfpc_pkg::pos_t'(sfpc_pkg::MIN_POSITION_RESET);
            settings_reg.max_position <= sfpc_pkg::pos_t'(sfpc_pkg::MAX_POSITION_RESET);
            settings_reg.step_rate    <= sfpc_pkg::rate_t'(sfpc_pkg::STEP_RATE_RESET);
        end
        else if (cfg.valid)
        begin
            case (sfpc_pkg::cfg_index_t'(cfg.index))
                sfpc_pkg::CFG_MIN_POSITION:
                begin
                    settings_reg.min_position <= cfg.data[sfpc_pkg::POSITION_BITS-1:0];
                end
                sfpc_pkg::CFG_MAX_POSITION:
                begin
                    settings_reg.max_position <= cfg.data[sfpc_pkg::POSITION_BITS-1:0];
                end
                sfpc_pkg::CFG_STEP_RATE:
                begin
                    settings_reg.step_rate <= cfg.data[sfpc_pkg::RATE_BITS-1:0];
                end
                default:
                begin
                    settings_reg <= settings_reg;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.step_pulse    = out_result_reg.step_pulse;
    assign result.step_outward  = out_result_reg.step_outward;
    assign result.position_now  = out_result_reg.position_now;
    assign result.position_goal = out_result_reg.position_goal;
    assign result.status        = out_result_reg.status;

endmodule
`default_nettype wire
